### hw/rtl/int_to_ascii_radix_assert.svh
// Assertion macros used by the port-level checker of the integer-to-text block.
`ifndef INT_TO_ASCII_RADIX_ASSERT_SVH
`define INT_TO_ASCII_RADIX_ASSERT_SVH
// Check cons in the same cycle as ante, on clk, while rst_n is high.
`define ITOA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check cons in the cycle after ante, on clk, while rst_n is high.
`define ITOA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### hw/rtl/itoa_pkg.sv
// Types, constants and helper functions of the integer-to-text block.
package itoa_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int TDATA_IN_W  = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int RADIX_W     = 6;
    localparam int DIGIT_W     = 6;
    localparam int CHAR_W      = 8;
    localparam int STEP_W      = $clog2(VALUE_WIDTH + 1);
    localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
    localparam int IDX_W       = $clog2(VALUE_WIDTH);

    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
    localparam logic [RADIX_W-1:0] RADIX_DEC   = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

    localparam logic [DIGIT_W-1:0] DIGIT_NINE = DIGIT_W'(9);
    localparam logic [DIGIT_W-1:0] DIGIT_TEN  = DIGIT_W'(10);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_Z     = 8'h7a;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;

    typedef struct packed {
        logic                   start;
        logic [VALUE_WIDTH-1:0] dividend;
        logic [RADIX_W-1:0]     divisor;
    } div_req_t;

    typedef struct packed {
        logic                   done;
        logic [VALUE_WIDTH-1:0] quotient;
        logic [DIGIT_W-1:0]     remainder;
    } div_rsp_t;

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] b;
        if (r < RADIX_MIN)
        begin
            b = RADIX_MIN;
        end
        else if (r > RADIX_MAX)
        begin
            b = RADIX_MAX;
        end
        else
        begin
            b = r;
        end
        return b;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d > DIGIT_NINE)
        begin
            c = CHAR_A + CHAR_W'(d - DIGIT_TEN);
        end
        else
        begin
            c = CHAR_ZERO + CHAR_W'(d);
        end
        return c;
    endfunction

endpackage

### hw/rtl/itoa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module itoa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/itoa_div.sv
// Iterative restoring divider: one quotient bit per cycle.
module itoa_div
    import itoa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [VALUE_WIDTH-1:0] quot_reg, quot_next;
    logic [DIGIT_W-1:0]     rem_reg, rem_next;
    logic [RADIX_W-1:0]     dvsr_reg, dvsr_next;
    logic [DIGIT_W:0]       rem_shift;
    logic [DIGIT_W:0]       rem_diff;
    logic                   fits;

    assign rem_shift = {rem_reg, quot_reg[VALUE_WIDTH-1]};
    assign rem_diff  = rem_shift - {1'b0, dvsr_reg};
    assign fits      = (rem_shift >= {1'b0, dvsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(VALUE_WIDTH);
            quot_next = req.dividend;
            rem_next  = '0;
            dvsr_next = req.divisor;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[VALUE_WIDTH-2:0], fits};
            rem_next  = fits ? rem_diff[DIGIT_W-1:0] : rem_shift[DIGIT_W-1:0];
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quot_reg;
    assign rsp.remainder = rem_reg;

endmodule

### hw/rtl/int_to_ascii_radix.sv
// Top level of the integer-to-text converter with configurable radix.
// Each digit is computed in the shared bit-serial divider (states START and WAIT).
// Each character is then read from the digit RAM and presented (READ, LOAD, SHOW).
// A negative value in radix 10 is preceded by a '-' character.
// rst_n clears the sequencer and sets radix to 10; the digit RAM is not cleared.
module int_to_ascii_radix
    import itoa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [RADIX_W-1:0]    cfg_data,        // [5:0] radix
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [TDATA_IN_W-1:0] s_axis_tdata,    // [VALUE_WIDTH-1:0] value, signed in radix 10
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [CHAR_W-1:0]     m_axis_tdata,    // [7:0] char_code
    output logic                  m_axis_tlast
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_LOAD  = 3'd4;
    localparam logic [2:0] ST_SHOW  = 3'd5;

    logic [2:0]             state_reg, state_next;
    logic [RADIX_W-1:0]     radix_reg, radix_next;
    logic [VALUE_WIDTH-1:0] quot_reg, quot_next;
    logic                   neg_reg, neg_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CHAR_W-1:0]      char_reg, char_next;
    logic                   last_reg, last_next;

    logic [RADIX_W-1:0]     base;
    logic [VALUE_WIDTH-1:0] in_value;
    logic                   in_neg;
    logic [CNT_W-1:0]       cnt_dec;
    logic                   in_fire;
    logic                   out_fire;
    logic                   wr_en;
    logic [DIGIT_W-1:0]     rd_digit;
    div_req_t               div_req;
    div_rsp_t               div_rsp;

    assign base      = clamp_radix(radix_reg);
    assign in_value  = s_axis_tdata[VALUE_WIDTH-1:0];
    assign in_neg    = in_value[VALUE_WIDTH-1] && (base == RADIX_DEC);
    assign cnt_dec   = cnt_reg - CNT_W'(1);
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign out_fire  = m_axis_tvalid && m_axis_tready;
    assign wr_en     = (state_reg == ST_WAIT) && div_rsp.done;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_SHOW);
    assign m_axis_tdata  = char_reg;
    assign m_axis_tlast  = last_reg;

    assign div_req.start    = (state_reg == ST_START);
    assign div_req.dividend = quot_reg;
    assign div_req.divisor  = base;

    itoa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    itoa_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (VALUE_WIDTH)
    ) u_digit_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cnt_reg[IDX_W-1:0]),
        .wr_data (div_rsp.remainder),
        .rd_addr (cnt_dec[IDX_W-1:0]),
        .rd_data (rd_digit)
    );

    always_comb
    begin
        state_next = state_reg;
        radix_next = radix_reg;
        quot_next  = quot_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        if (cfg_valid && cfg_ready)
        begin
            radix_next = cfg_data;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    quot_next  = in_neg ? (~in_value + VALUE_WIDTH'(1)) : in_value;
                    neg_next   = in_neg;
                    cnt_next   = '0;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_rsp.done)
                begin
                    quot_next = div_rsp.quotient;
                    cnt_next  = cnt_reg + CNT_W'(1);
                    if (div_rsp.quotient != '0)
                    begin
                        state_next = ST_START;
                    end
                    else if (neg_reg)
                    begin
                        char_next  = CHAR_MINUS;
                        last_next  = 1'b0;
                        state_next = ST_SHOW;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                char_next  = digit_char(rd_digit);
                last_next  = (cnt_reg == CNT_W'(1));
                cnt_next   = cnt_dec;
                state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                if (out_fire)
                begin
                    state_next = last_reg ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            radix_reg <= RADIX_RESET;
            neg_reg   <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            radix_reg <= radix_next;
            neg_reg   <= neg_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

endmodule

### hw/rtl/itoa_checker.sv
// Port-level assertion checker for the integer-to-text block, with its bind.
`include "int_to_ascii_radix_assert.svh"

module itoa_checker
    import itoa_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [CHAR_W-1:0] m_axis_tdata,
    input logic              m_axis_tlast
);

    logic            char_legal;
    logic            in_fire;
    logic            out_stall;
    logic            minus_out;
    logic [CHAR_W:0] out_word;

    assign char_legal = (m_axis_tdata == CHAR_MINUS)
        || ((m_axis_tdata >= CHAR_ZERO) && (m_axis_tdata <= CHAR_NINE))
        || ((m_axis_tdata >= CHAR_A) && (m_axis_tdata <= CHAR_Z));
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign minus_out = m_axis_tvalid && (m_axis_tdata == CHAR_MINUS);
    assign out_word  = {m_axis_tlast, m_axis_tdata};

    `ITOA_ASSERT_IMPL(a_idle_no_output, s_axis_tready, !m_axis_tvalid, "ready while busy")
    `ITOA_ASSERT_NEXT(a_busy_after_accept, in_fire, !s_axis_tready, "ready after accept")
    `ITOA_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_word), "stall broken")
    `ITOA_ASSERT_IMPL(a_char_legal, m_axis_tvalid, char_legal, "illegal character")
    `ITOA_ASSERT_IMPL(a_minus_not_last, minus_out, !m_axis_tlast, "minus marked last")

endmodule

bind int_to_ascii_radix itoa_checker u_itoa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

### tb/sv/itoa_text_checker.sv
`timescale 1ns / 1ps
// Checker that predicts the character stream of the integer-to-text block and compares it.
module itoa_text_checker
    import itoa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [RADIX_W-1:0]    cfg_data,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [TDATA_IN_W-1:0] s_axis_tdata,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [CHAR_W-1:0]     m_axis_tdata,
    input  logic                  m_axis_tlast,
    output int                    fails,
    output int                    pending
);

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } text_char_t;

    text_char_t         expected_text_q[$];
    logic [RADIX_W-1:0] radix_reg;
    int                 err_cnt;

    function automatic void render_value(input logic [VALUE_WIDTH-1:0] v,
                                         input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0]     base;
        logic [VALUE_WIDTH-1:0] mag;
        logic [DIGIT_W-1:0]     digits [VALUE_WIDTH];
        logic [DIGIT_W-1:0]     d;
        logic                   neg;
        text_char_t             c;
        int                     n;
        base = (r < RADIX_MIN) ? RADIX_MIN : ((r > RADIX_MAX) ? RADIX_MAX : r);
        neg  = v[VALUE_WIDTH-1] && (base == RADIX_DEC);
        mag  = neg ? (~v + 1'b1) : v;
        n    = 0;
        do
        begin
            digits[n] = DIGIT_W'(mag % VALUE_WIDTH'(base));
            mag       = mag / VALUE_WIDTH'(base);
            n++;
        end
        while (mag != '0 && n < VALUE_WIDTH);
        if (neg)
        begin
            c.code = CHAR_MINUS;
            c.last = 1'b0;
            expected_text_q.push_back(c);
        end
        for (int i = n - 1; i >= 0; i--)
        begin
            d      = digits[i];
            c.code = (d > DIGIT_NINE) ? CHAR_A + CHAR_W'(d - DIGIT_TEN) : CHAR_ZERO + CHAR_W'(d);
            c.last = (i == 0);
            expected_text_q.push_back(c);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        text_char_t exp_c;
        if (!rst_n)
        begin
            radix_reg = RADIX_RESET;
            expected_text_q.delete();
            err_cnt   = 0;
            fails   <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                radix_reg = cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                render_value(s_axis_tdata[VALUE_WIDTH-1:0], radix_reg);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_text_q.size() == 0)
                begin
                    $error("char_code with no value pending: actual %h, last %b",
                           m_axis_tdata, m_axis_tlast);
                    err_cnt++;
                end
                else
                begin
                    exp_c = expected_text_q.pop_front();
                    if (m_axis_tdata !== exp_c.code)
                    begin
                        $error("char_code mismatch: expected %h, actual %h",
                               exp_c.code, m_axis_tdata);
                        err_cnt++;
                    end
                    if (m_axis_tlast !== exp_c.last)
                    begin
                        $error("last_char mismatch: expected %b, actual %b",
                               exp_c.last, m_axis_tlast);
                        err_cnt++;
                    end
                end
            end
            fails   <= err_cnt + expected_text_q.size() * 0;
            pending <= expected_text_q.size();
        end
    end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the integer-to-text testbench: clock, reset, stimulus and verdict.
module tb_top;
    import itoa_pkg::*;

    localparam int HOLD_CYCLES  = 2500;
    localparam int SETTLE       = 40;
    localparam int PHASE_ITEMS  = 32;
    localparam int PHASES       = 8;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [RADIX_W-1:0]    cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [TDATA_IN_W-1:0] s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [CHAR_W-1:0]     m_axis_tdata;
    logic                  m_axis_tlast;
    int                    fails;
    int                    pending;

    logic                  tx_idle_on;
    logic                  rx_idle_on;
    logic                  hold_req;
    logic                  hold_taken;
    logic [RADIX_W-1:0]    cur_radix;

    int_to_ascii_radix dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    itoa_text_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .fails         (fails),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic send_value(input logic [VALUE_WIDTH-1:0] v);
        int gap;
        gap = 0;
        while (tx_idle_on && $urandom_range(0, 99) < 21)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_IN_W'(v);
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_radix(input logic [RADIX_W-1:0] r);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= r;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_radix  = r;
    endtask

    function automatic logic [VALUE_WIDTH-1:0] pick_value(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0]     b;
        logic [VALUE_WIDTH-1:0] p;
        int                     k;
        b = (r < RADIX_MIN) ? RADIX_MIN : ((r > RADIX_MAX) ? RADIX_MAX : r);
        case ($urandom_range(0, 7))
            0: return VALUE_WIDTH'($urandom_range(0, 2 * b));
            1: return -VALUE_WIDTH'($urandom_range(1, 1000));
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return {1'b1, {(VALUE_WIDTH-1){1'b0}}};
                    1: return {1'b0, {(VALUE_WIDTH-1){1'b1}}};
                    2: return '1;
                    default: return '0;
                endcase
            end
            3:
            begin
                p = 1;
                k = $urandom_range(1, 8);
                repeat (k) p = p * VALUE_WIDTH'(b);
                return p - VALUE_WIDTH'($urandom_range(0, 1));
            end
            4: return VALUE_WIDTH'($urandom_range(0, 65535));
            default: return VALUE_WIDTH'($urandom);
        endcase
    endfunction

    initial
    begin
        m_axis_tready <= 1'b0;
        hold_taken     = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= !(rx_idle_on && $urandom_range(0, 99) < 21);
            end
        end
    end

    initial
    begin
        logic [RADIX_W-1:0] plan [PHASES];
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        hold_req       = 1'b0;
        cur_radix      = RADIX_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset radix is decimal: signs, zero and the range ends
        send_value(0);
        send_value(1);
        send_value(-1);
        send_value(9);
        send_value(10);
        send_value(32'h7fffffff);
        send_value(32'h80000000);
        send_value(-10);
        send_value(123);

        set_radix(RADIX_W'(2));
        send_value(0);
        send_value(1);
        send_value(32'hffffffff);
        send_value(32'h80000000);
        send_value(32'h7fffffff);

        set_radix(RADIX_W'(36));
        send_value(35);
        send_value(36);
        send_value(32'hffffffff);
        send_value(32'h80000000);

        // out-of-range radix settings clamp to the nearest legal base
        set_radix(RADIX_W'(0));
        send_value(5);
        set_radix(RADIX_W'(1));
        send_value(6);
        set_radix(RADIX_W'(63));
        send_value(35);
        set_radix(RADIX_W'(37));
        send_value(71);

        set_radix(RADIX_W'(16));
        send_value(32'hdeadbeef);
        send_value(-1);

        plan[0] = RADIX_W'(10);
        plan[1] = RADIX_W'(16);
        plan[2] = RADIX_W'(2);
        plan[3] = RADIX_W'(36);
        plan[4] = RADIX_W'(7);
        plan[5] = RADIX_W'(10);
        plan[6] = RADIX_W'($urandom_range(0, 63));
        plan[7] = RADIX_W'($urandom_range(3, 35));

        for (int ph = 0; ph < PHASES; ph++)
        begin
            set_radix(plan[ph]);
            tx_idle_on = (ph != 5);
            rx_idle_on = (ph != 5);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // hold the output side while the sender keeps offering values
                if (ph == 1 && i == 4)
                begin
                    hold_req = 1'b1;
                end
                send_value(pick_value(cur_radix));
            end
        end

        wait_drained();
        if (fails == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/itoa_pkg.sv
hw/rtl/itoa_ram.sv
hw/rtl/itoa_div.sv
hw/rtl/int_to_ascii_radix.sv
hw/rtl/itoa_checker.sv
tb/sv/itoa_text_checker.sv
tb/sv/tb_top.sv
